// File: rtl/pfla_pkg.sv
package pfla_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_t;

  // Request codes carried in tuser
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  // Payload widths fixed by the stream format
  localparam int PAGE_FIELD_W = 8;

endpackage

// File: rtl/page_free_list_allocator.sv
// Page frame allocator built on a free list of singly linked page chains.
// Requests enter on the s_axis channel: tuser selects allocate or free,
// tdata carries the page count and the head of a chain to release.
// Each request gives one result on m_axis: the first page granted (or
// the "no page" code POOL_PAGES) in tdata and a done/nothing-done flag
// in tuser.
// One request is in work at a time. A request walks the link table one
// link per cycle through a single read port of the link memory. An
// allocate stops after its page count or at the end of the free list, a
// free at the end of its chain or after POOL_PAGES pages. An empty list,
// a zero count and an out-of-range chain head skip the walk.
// After reset the block writes the initial links of all pages (page i
// points to page i+1) with s_axis_tready low.
// The result sits in an output register; the next request is accepted
// while it waits, and a finished request holds in its last state until
// the receiver takes the previous result.
module page_free_list_allocator #(
  parameter int POOL_PAGES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] page_count, [15:8] chain_head
  input  logic [0:0]  s_axis_tuser,   // [0] func
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] granted_head
  output logic [0:0]  m_axis_tuser    // [0] status
);

  localparam int AW  = $clog2(POOL_PAGES);
  localparam int LW  = $clog2(POOL_PAGES + 1);
  localparam int CW  = (AW > pfla_pkg::PAGE_FIELD_W) ? AW : pfla_pkg::PAGE_FIELD_W;
  localparam int PFW = pfla_pkg::PAGE_FIELD_W;

  localparam logic [LW-1:0]  NONE_LINK = LW'(POOL_PAGES);
  localparam logic [PFW-1:0] NONE_OUT  = PFW'(POOL_PAGES);

  pfla_pkg::state_t state, state_next;

  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  limit, limit_next;
  logic           op, op_next;
  logic [AW-1:0]  cur, cur_next;
  logic [AW-1:0]  first, first_next;
  logic [LW-1:0]  free_head, free_head_next;
  logic [PFW-1:0] res_head, res_head_next;
  logic           res_status, res_status_next;
  logic           out_valid, out_valid_next;
  logic [PFW-1:0] out_head, out_head_next;
  logic           out_status, out_status_next;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [LW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [LW-1:0]  link;

  logic [PFW-1:0] in_count;
  logic [PFW-1:0] in_head;
  logic           in_func;
  logic           in_xfer;
  logic           link_ok;
  logic           step_ok;
  logic           head_ok;
  logic           free_ok;

  assign in_count = s_axis_tdata[7:0];
  assign in_head  = s_axis_tdata[15:8];
  assign in_func  = s_axis_tuser[0];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // Shared walk test: link in range and step budget left
  assign link_ok = (link < NONE_LINK);
  assign step_ok = (cnt < limit) && link_ok;
  assign head_ok = (32'(in_head) < POOL_PAGES);
  assign free_ok = (free_head < NONE_LINK);

  pfla_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (link)
  );

  // Next state, datapath and memory control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    limit_next      = limit;
    op_next         = op;
    cur_next        = cur;
    first_next      = first;
    free_head_next  = free_head;
    res_head_next   = res_head;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_head_next   = out_head;
    out_status_next = out_status;
    ram_we          = 1'b0;
    ram_waddr       = cur;
    ram_wdata       = NONE_LINK;
    ram_raddr       = cur;
    s_axis_tready   = 1'b0;

    // Drop the result once the receiver takes it
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      pfla_pkg::ST_INIT: begin
        // Write the initial chain, one entry per cycle
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt);
        ram_wdata = LW'(cnt) + LW'(1);
        cnt_next  = cnt + CW'(1);
        if (cnt == CW'(POOL_PAGES - 1)) begin
          cnt_next   = '0;
          state_next = pfla_pkg::ST_IDLE;
        end
      end

      pfla_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          op_next  = in_func;
          cnt_next = '0;
          if (in_func == pfla_pkg::FUNC_ALLOC) begin
            // Start at the free head; fetch its link
            first_next = AW'(free_head);
            cur_next   = AW'(free_head);
            ram_raddr  = AW'(free_head);
            limit_next = CW'(in_count) - CW'(1);
            if (!free_ok || in_count == '0) begin
              res_head_next   = NONE_OUT;
              res_status_next = pfla_pkg::STATUS_NONE;
              state_next      = pfla_pkg::ST_RESP;
            end else begin
              state_next = pfla_pkg::ST_WALK;
            end
          end else begin
            // Start at the chain head; fetch its link
            first_next = AW'(in_head);
            cur_next   = AW'(in_head);
            ram_raddr  = AW'(in_head);
            limit_next = CW'(POOL_PAGES - 1);
            if (!head_ok) begin
              res_head_next   = NONE_OUT;
              res_status_next = pfla_pkg::STATUS_NONE;
              state_next      = pfla_pkg::ST_RESP;
            end else begin
              state_next = pfla_pkg::ST_WALK;
            end
          end
        end
      end

      pfla_pkg::ST_WALK: begin
        if (step_ok) begin
          // Advance one link and fetch the next
          cur_next  = AW'(link);
          ram_raddr = AW'(link);
          cnt_next  = cnt + CW'(1);
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = cur;
          res_status_next = pfla_pkg::STATUS_DONE;
          if (op == pfla_pkg::FUNC_ALLOC) begin
            // Cut the granted chain off the free list
            ram_wdata      = NONE_LINK;
            free_head_next = link_ok ? link : NONE_LINK;
            res_head_next  = PFW'(first);
          end else begin
            // Splice the released chain onto the free list
            ram_wdata      = free_head;
            free_head_next = LW'(first);
            res_head_next  = NONE_OUT;
          end
          state_next = pfla_pkg::ST_RESP;
        end
      end

      pfla_pkg::ST_RESP: begin
        // Hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          out_valid_next  = 1'b1;
          out_head_next   = res_head;
          out_status_next = res_status;
          state_next      = pfla_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pfla_pkg::ST_INIT;
        cnt_next   = '0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfla_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      free_head <= free_head_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    limit      <= limit_next;
    op         <= op_next;
    cur        <= cur_next;
    first      <= first_next;
    res_head   <= res_head_next;
    res_status <= res_status_next;
    out_head   <= out_head_next;
    out_status <= out_status_next;
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_head;
  assign m_axis_tuser[0] = out_status;

  // The free head is always a page or the "no page" code
  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= NONE_LINK)
    else $error("free head out of range");

  // The walk never runs past its step budget
  a_walk_budget: assert property (@(posedge clk) disable iff (rst)
    (state == pfla_pkg::ST_WALK) |-> (cnt <= limit))
    else $error("walk counter past its limit");

  // One request at a time: no transfer in the cycle after a transfer
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A new result only comes from the response state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == pfla_pkg::ST_RESP))
    else $error("result raised outside response state");

endmodule

// File: rtl/pfla_ram.sv
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
